// ===== hw/rtl/dmt_pkg.sv =====
// package: deque sizes, codes, shared types and ring addressing
package dmt_pkg;

  localparam int CAPACITY = 512;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_NOP        = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_PREV,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    status_e                    status;
    logic signed [DATA_W-1:0]   popped;
    logic signed [DATA_W-1:0]   max;
    logic        [CNT_W-1:0]    count;
    logic                       ordered;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [DATA_W-1:0]   wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W+1-IDX_W){1'b0}}, head} + {1'b0, offset};
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dmt_ram.sv =====
// generic single-write, single-read ram with registered read data
module dmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmt_core.sv =====
// deque control: request sequencing, ring pointers, max rescan and result build
module dmt_core import dmt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     res_free_i,
  output logic                     res_valid_o,
  output result_t                  res_o,
  output mem_req_t                 mem_o,
  input  logic [DATA_W-1:0]        rdata_i
);

  state_e state_q, state_d;

  kind_e                    kind_q, kind_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic signed [DATA_W-1:0] first_q, first_d;
  logic signed [DATA_W-1:0] second_q, second_d;
  logic [CNT_W-1:0]         scan_idx_q, scan_idx_d;
  logic                     scan_pend_q, scan_pend_d;
  logic signed [DATA_W-1:0] scan_max_q, scan_max_d;

  logic [IDX_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [DATA_W-1:0] max_q, max_d;
  logic [CNT_W-1:0]         asc_q, asc_d;

  logic                     full, empty, accept, commit, do_write;
  logic [IDX_W-1:0]         tail_pos, prev_pos, back_pos, head_dec, scan_pos;
  logic [CNT_W-1:0]         scan_len;
  logic signed [DATA_W-1:0] rdata_s;

  logic [IDX_W-1:0]         new_head;
  logic [CNT_W-1:0]         new_count, new_asc;
  logic signed [DATA_W-1:0] new_max, popped;
  status_e                  status;

  assign full     = (count_q >= CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign tail_pos = ring_pos(head_q, count_q - CNT_W'(1));
  assign prev_pos = ring_pos(head_q, count_q - CNT_W'(2));
  assign back_pos = ring_pos(head_q, count_q);
  assign scan_pos = ring_pos(head_q, scan_idx_q);
  assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
  assign scan_len = count_q - CNT_W'(1);
  assign rdata_s  = $signed(rdata_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_COMMIT);
  assign commit      = res_valid_o && res_free_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        if (kind_q == KIND_POP_BACK && count_q >= CNT_W'(2)) state_d = ST_READ_PREV;
        else state_d = ST_COMMIT;
      end
      ST_READ_PREV: begin
        if (first_q == max_q) state_d = ST_SCAN;
        else state_d = ST_COMMIT;
      end
      ST_SCAN: begin
        if (scan_idx_q == scan_len) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (res_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // operation result from the latched reads
  always_comb begin
    status    = STATUS_DONE;
    popped    = '0;
    new_head  = head_q;
    new_count = count_q;
    new_max   = max_q;
    new_asc   = asc_q;
    do_write  = 1'b0;
    case (kind_q)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          do_write  = 1'b1;
          new_count = count_q + CNT_W'(1);
          if (value_q > max_q) new_max = value_q;
          if (kind_q == KIND_PUSH_BACK) begin
            if (!empty && first_q < value_q) new_asc = asc_q + CNT_W'(1);
          end else begin
            if (!empty && value_q < first_q) new_asc = asc_q + CNT_W'(1);
            new_head = head_dec;
          end
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          popped    = first_q;
          new_count = count_q - CNT_W'(1);
          if (count_q >= CNT_W'(2) && second_q < first_q && asc_q != '0) begin
            new_asc = asc_q - CNT_W'(1);
          end
          if (new_count == '0) begin
            new_head = '0;
            new_asc  = '0;
          end
          if (first_q == max_q) begin
            new_max = (new_count == '0) ? MOST_NEG : scan_max_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.status  = status;
  assign res_o.popped  = popped;
  assign res_o.max     = new_max;
  assign res_o.count   = new_count;
  assign res_o.ordered = (new_asc == '0);

  // datapath registers and memory port
  always_comb begin
    kind_d      = kind_q;
    value_d     = value_q;
    first_d     = first_q;
    second_d    = second_q;
    scan_idx_d  = scan_idx_q;
    scan_pend_d = scan_pend_q;
    scan_max_d  = scan_max_q;
    head_d      = head_q;
    count_d     = count_q;
    max_d       = max_q;
    asc_d       = asc_q;
    mem_o.we    = commit && do_write;
    mem_o.waddr = (kind_q == KIND_PUSH_FRONT) ? head_dec : back_pos;
    mem_o.wdata = value_q;
    mem_o.raddr = tail_pos;
    case (state_q)
      ST_IDLE: begin
        mem_o.raddr = (kind_e'(kind_i) == KIND_PUSH_FRONT) ? head_q : tail_pos;
        if (accept) begin
          kind_d  = kind_e'(kind_i);
          value_d = value_i;
        end
      end
      ST_READ: begin
        mem_o.raddr = prev_pos;
        first_d     = rdata_s;
      end
      ST_READ_PREV: begin
        second_d    = rdata_s;
        scan_idx_d  = '0;
        scan_pend_d = 1'b0;
        scan_max_d  = MOST_NEG;
      end
      ST_SCAN: begin
        mem_o.raddr = scan_pos;
        if (scan_idx_q != scan_len) begin
          scan_idx_d  = scan_idx_q + CNT_W'(1);
          scan_pend_d = 1'b1;
        end else begin
          scan_pend_d = 1'b0;
        end
        if (scan_pend_q && rdata_s > scan_max_q) scan_max_d = rdata_s;
      end
      ST_COMMIT: begin
        if (commit) begin
          head_d  = new_head;
          count_d = new_count;
          max_d   = new_max;
          asc_d   = new_asc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      max_q       <= MOST_NEG;
      asc_q       <= '0;
      scan_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      max_q       <= max_d;
      asc_q       <= asc_d;
      scan_pend_q <= scan_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    value_q    <= value_d;
    first_q    <= first_d;
    second_q   <= second_d;
    scan_idx_q <= scan_idx_d;
    scan_max_q <= scan_max_d;
  end

endmodule

// ===== hw/rtl/deque_with_max_tracking_top.sv =====
// top level: deque with max tracking, item ram, core and result register
//
//   channel | valid / ready             | payload
//   --------+---------------------------+-----------------------------------------
//   request | in_valid_i / in_ready_o   | kind_i, value_i
//   result  | out_valid_o / out_ready_i | status_o, popped_value_o, peak_value_o,
//           |                           | item_count_o, is_ordered_o
//
// one request at a time: a push, a nop, an ignored request or a pop that empties
// the deque passes the read state before its result, a pop that keeps the max
// also the read of the item before it, and a pop of the max then rescans the n
// items left, one item ram read per cycle; a new request is taken the cycle after
// the result leaves; the item ram has no reset and no clearing pass, and only data
// of live entries is used; a result waits in the output register; a new request is
// taken meanwhile, and its own result holds in the core until the register frees up
module deque_with_max_tracking_top import dmt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic signed [DATA_W-1:0] peak_value_o,
  output logic [CNT_W-1:0]         item_count_o,
  output logic                     is_ordered_o
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;
  result_t           res;
  logic              res_valid, res_free;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  dmt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  dmt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_free) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign popped_value_o = out_q.popped;
  assign peak_value_o   = out_q.max;
  assign item_count_o   = out_q.count;
  assign is_ordered_o   = out_q.ordered;

endmodule
